>>> src/euclidean_distance_cost_map_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Euclidean distance cost map
// Short forms for the same-cycle and next-cycle implications used in the RTL.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_COST_MAP_MACROS_SVH
`define EUCLIDEAN_DISTANCE_COST_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDCM_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EDCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/edcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean distance cost map package
// Field widths, register indexes, action codes and cost constants.
// ----------------------------------------------------------------------------
package edcm_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int GRAY_W    = 8;
  localparam int DIST_W    = 18;
  localparam int COST_W    = 5;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_RESET_SIZE   = 9'd256;

  // Input actions.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Cost from a Q1.24 ratio raised to the seventh power, scaled by twenty.
  localparam int FRAC       = 24;
  localparam int RATIO_W    = FRAC + 1;
  localparam int POW_STEPS  = 6;
  localparam int COST_SCALE = 20;
  localparam int COST_MAX   = 20;

  localparam logic [DIST_W-1:0] DIST_SAT = '1;

endpackage

>>> src/edcm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean distance cost map channels
// Valid/ready channels for pixel and command beats and for result beats.
// ----------------------------------------------------------------------------
interface edcm_in_if;
  import edcm_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [GRAY_W-1:0] gray;

  modport source (output valid, output action, output gray, input ready);
  modport sink   (input valid, input action, input gray, output ready);
endinterface

interface edcm_out_if;
  import edcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] squared_distance;
  logic [COST_W-1:0] cost;
  logic              no_black;
  logic              last;

  modport source (output valid, output squared_distance, output cost, output no_black,
                  output last, input ready);
  modport sink   (input valid, input squared_distance, input cost, input no_black,
                  input last, output ready);
endinterface

>>> src/euclidean_distance_cost_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean distance cost map
// Exact squared Euclidean distance transform with an inverted seventh-power
// cost, built around a column store, a distance store and an envelope stack.
// ----------------------------------------------------------------------------
// A load beat writes one pixel in raster order. After the last pixel the
// block is busy and holds ready low. The down and up column passes read
// both neighbours of each pixel, then write. The row pass builds the lower
// envelope on a forward scan and writes each distance on a backward scan.
// A site whose start must be computed and lies inside the row goes through
// the bit-serial start divider before it is pushed. Each envelope pop
// reloads the stack top from the envelope store on both scans. A fetch beat
// runs one store read, the bit-serial ratio divider, six multiplies, a
// scaling step and the hand-over to the output register, which waits for
// an earlier result to be taken, before the next beat is accepted. An
// image without black pixels skips the cost steps. The finished result
// sits in the output register while the next beat is accepted.
`include "euclidean_distance_cost_map_macros.svh"

module euclidean_distance_cost_map #(
  parameter int MAX_WIDTH  = edcm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = edcm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [edcm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [edcm_pkg::CFG_W-1:0]        cfg_data_i,
  edcm_in_if.sink                           in_i,
  edcm_out_if.source                        out_o
);
  import edcm_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int PIX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int PAW  = $clog2(PIX);
  localparam int PCW  = $clog2(PIX + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int INF  = MAX_WIDTH + MAX_HEIGHT;
  localparam int CW   = $clog2(INF + 1);
  localparam int FW   = $clog2((MAX_WIDTH - 1) * (MAX_WIDTH - 1) + INF * INF + 1);
  localparam int DVW  = FW + 2 * AW + 2;
  localparam int LMW  = WW + AW + 1;
  localparam int CMPW = FW + LMW;
  localparam int EW   = CW + 2 * AW;
  localparam int CNTW = $clog2(RATIO_W + 1);

  localparam logic [4:0] ST_LOAD  = 5'd0;
  localparam logic [4:0] ST_DN_RD = 5'd1;
  localparam logic [4:0] ST_DN_WR = 5'd2;
  localparam logic [4:0] ST_UP_RD = 5'd3;
  localparam logic [4:0] ST_UP_WR = 5'd4;
  localparam logic [4:0] ST_R0    = 5'd5;
  localparam logic [4:0] ST_R1    = 5'd6;
  localparam logic [4:0] ST_F_RDG = 5'd7;
  localparam logic [4:0] ST_F_G   = 5'd8;
  localparam logic [4:0] ST_F_C1  = 5'd9;
  localparam logic [4:0] ST_F_C2  = 5'd10;
  localparam logic [4:0] ST_F_LD  = 5'd11;
  localparam logic [4:0] ST_F_N1  = 5'd12;
  localparam logic [4:0] ST_F_N2  = 5'd13;
  localparam logic [4:0] ST_F_N3  = 5'd14;
  localparam logic [4:0] ST_F_DIV = 5'd15;
  localparam logic [4:0] ST_B_C   = 5'd16;
  localparam logic [4:0] ST_B_LD  = 5'd17;
  localparam logic [4:0] ST_OUT   = 5'd18;
  localparam logic [4:0] ST_Q_RD  = 5'd19;
  localparam logic [4:0] ST_Q_DIV = 5'd20;
  localparam logic [4:0] ST_Q_POW = 5'd21;
  localparam logic [4:0] ST_Q_CST = 5'd22;
  localparam logic [4:0] ST_Q_PUT = 5'd23;

  function automatic logic [FW-1:0] fdist(input logic [AW-1:0] x, input logic [AW-1:0] i,
                                          input logic [CW-1:0] g);
    logic [AW-1:0]   dx;
    logic [2*AW-1:0] sx;
    logic [2*CW-1:0] sg;
    dx = (x > i) ? x - i : i - x;
    sx = dx * dx;
    sg = g * g;
    return FW'(sx) + FW'(sg);
  endfunction

  // Stores.
  logic [CW-1:0] col_mem  [PIX];
  logic [FW-1:0] dist_mem [PIX];
  logic [EW-1:0] env_mem  [MAX_WIDTH];

  logic           col_we, dist_we, env_we;
  logic [PAW-1:0] col_wa, col_ra, col_rb, dist_wa, dist_ra;
  logic [CW-1:0]  col_wd, col_a_q, col_b_q;
  logic [FW-1:0]  dist_wd, dist_rd_q;
  logic [AW-1:0]  env_wa, env_ra;
  logic [EW-1:0]  env_wd, env_rd_q;

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_a_q <= col_mem[col_ra];
    col_b_q <= col_mem[col_rb];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (env_we) env_mem[env_wa] <= env_wd;
    env_rd_q <= env_mem[env_ra];
  end

  // Control registers.
  logic [4:0]       state_q, state_d;
  logic [CFG_W-1:0] img_w_q, img_w_d, img_h_q, img_h_d;
  logic [PCW-1:0]   load_cnt_q, load_cnt_d, fetch_cnt_q, fetch_cnt_d;
  logic             any_black_q, any_black_d;
  logic             out_valid_q, out_valid_d;
  logic [FW-1:0]    max_q, max_d;

  // Working registers.
  logic [PAW-1:0]     idx_q, idx_d, base_q, base_d;
  logic [RW-1:0]      row_q, row_d;
  logic [AW-1:0]      u_q, u_d, q_q, q_d, top_s_q, top_s_d, top_t_q, top_t_d, quot_q, quot_d;
  logic [CW-1:0]      top_g_q, top_g_d, g_u_q, g_u_d;
  logic [FW-1:0]      fa_q, fa_d, nu_q, nu_d, rem_q, rem_d;
  logic [AW:0]        den_q, den_d;
  logic [DVW-1:0]     dv_q, dv_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [FW+1:0]      crem_q, crem_d;
  logic [RATIO_W-1:0] r_q, r_d, p_q, p_d;
  logic [DIST_W-1:0]  res_dist_q, res_dist_d, out_dist_q, out_dist_d;
  logic [COST_W-1:0]  res_cost_q, res_cost_d, out_cost_q, out_cost_d;
  logic               res_nb_q, res_nb_d, out_nb_q, out_nb_d, out_last_q, out_last_d;

  // Effective image size.
  logic [WW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [PCW-1:0] total;
  assign w_eff = (img_w_q == '0) ? WW'(1) :
                 ((32'(img_w_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(img_w_q));
  assign h_eff = (img_h_q == '0) ? RW'(1) :
                 ((32'(img_h_q) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(img_h_q));
  assign total = PCW'(32'(w_eff) * 32'(h_eff));

  // Shared squared-distance unit.
  logic [AW-1:0] fd_x, fd_i;
  logic [CW-1:0] fd_g;
  logic [FW-1:0] fd_res;

  always_comb begin
    case (state_q)
      ST_F_C1: begin
        fd_x = top_t_q; fd_i = top_s_q; fd_g = top_g_q;
      end
      ST_F_C2: begin
        fd_x = top_t_q; fd_i = u_q; fd_g = g_u_q;
      end
      ST_F_N1: begin
        fd_x = '0; fd_i = u_q; fd_g = g_u_q;
      end
      ST_F_N2: begin
        fd_x = '0; fd_i = top_s_q; fd_g = top_g_q;
      end
      default: begin
        fd_x = u_q; fd_i = top_s_q; fd_g = top_g_q;
      end
    endcase
  end
  assign fd_res = fdist(fd_x, fd_i, fd_g);

  logic [LMW-1:0] lim;
  assign lim = LMW'(w_eff - WW'(1)) * LMW'(den_q);

  logic in_ready, in_beat, out_beat;
  assign in_ready = (state_q == ST_LOAD) || (state_q == ST_OUT);
  assign in_beat  = in_i.valid && in_ready;
  assign out_beat = out_valid_q && out_o.ready;

  always_comb begin
    logic [PCW-1:0] li;
    logic           blk, push_en, next_u, dbit;
    logic [AW-1:0]  push_start, qn;
    logic [FW-1:0]  num;
    logic [FW+1:0]  m_ext, cr;
    logic [2*RATIO_W-1:0] prod;
    logic [RATIO_W+COST_W-1:0] sc;

    state_d = state_q; img_w_d = img_w_q; img_h_d = img_h_q;
    load_cnt_d = load_cnt_q; fetch_cnt_d = fetch_cnt_q; any_black_d = any_black_q;
    out_valid_d = out_valid_q; max_d = max_q;
    idx_d = idx_q; base_d = base_q; row_d = row_q; u_d = u_q; q_d = q_q;
    top_s_d = top_s_q; top_t_d = top_t_q; top_g_d = top_g_q; g_u_d = g_u_q;
    quot_d = quot_q; fa_d = fa_q; nu_d = nu_q; rem_d = rem_q;
    den_d = den_q; dv_d = dv_q; cnt_d = cnt_q; crem_d = crem_q; r_d = r_q; p_d = p_q;
    res_dist_d = res_dist_q; res_cost_d = res_cost_q; res_nb_d = res_nb_q;
    out_dist_d = out_dist_q; out_cost_d = out_cost_q; out_nb_d = out_nb_q;
    out_last_d = out_last_q;

    col_we = 1'b0; col_wa = '0; col_wd = '0; col_ra = '0; col_rb = '0;
    dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = '0;
    env_we = 1'b0; env_wa = '0; env_wd = '0; env_ra = '0;

    li = '0; blk = 1'b0; push_en = 1'b0; next_u = 1'b0; dbit = 1'b0;
    push_start = '0; qn = '0; num = '0; cr = '0; prod = '0; sc = '0;
    m_ext = (FW+2)'(max_q) + (FW+2)'(1);

    if (out_beat) out_valid_d = 1'b0;

    case (state_q)
      ST_LOAD, ST_OUT: begin
        if (in_beat && in_i.action == ACT_LOAD) begin
          // A load beat while results are pending starts a new image.
          li  = (state_q == ST_OUT) ? '0 : load_cnt_q;
          blk = (in_i.gray == '0);
          col_we = 1'b1;
          col_wa = PAW'(li);
          col_wd = blk ? '0 : CW'(INF);
          any_black_d = ((li == '0) ? 1'b0 : any_black_q) | blk;
          if (li + PCW'(1) == total) begin
            load_cnt_d = '0;
            max_d = '0;
            if (h_eff > RW'(1)) begin
              idx_d = PAW'(w_eff);
              state_d = ST_DN_RD;
            end else begin
              base_d = '0; row_d = '0;
              state_d = ST_R0;
            end
          end else begin
            load_cnt_d = li + PCW'(1);
            state_d = ST_LOAD;
          end
        end else if (in_beat && state_q == ST_OUT) begin
          dist_ra = PAW'(fetch_cnt_q);
          state_d = ST_Q_RD;
        end
      end
      ST_DN_RD: begin
        col_ra = idx_q;
        col_rb = idx_q - PAW'(w_eff);
        state_d = ST_DN_WR;
      end
      ST_DN_WR: begin
        col_we = 1'b1;
        col_wa = idx_q;
        col_wd = (col_a_q == '0) ? '0 :
                 ((col_b_q == CW'(INF)) ? CW'(INF) : col_b_q + CW'(1));
        if (PCW'(idx_q) + PCW'(1) == total) begin
          state_d = ST_UP_RD;
        end else begin
          idx_d = idx_q + PAW'(1);
          state_d = ST_DN_RD;
        end
      end
      ST_UP_RD: begin
        col_ra = idx_q;
        col_rb = idx_q - PAW'(w_eff);
        state_d = ST_UP_WR;
      end
      ST_UP_WR: begin
        if (col_a_q < col_b_q) begin
          col_we = 1'b1;
          col_wa = idx_q - PAW'(w_eff);
          col_wd = col_a_q + CW'(1);
        end
        if (PCW'(idx_q) == PCW'(w_eff)) begin
          base_d = '0; row_d = '0;
          state_d = ST_R0;
        end else begin
          idx_d = idx_q - PAW'(1);
          state_d = ST_UP_RD;
        end
      end
      ST_R0: begin
        col_ra = base_q;
        state_d = ST_R1;
      end
      ST_R1: begin
        top_s_d = '0; top_t_d = '0; top_g_d = col_a_q; q_d = '0;
        env_we = 1'b1; env_wa = '0; env_wd = {col_a_q, AW'(0), AW'(0)};
        if (w_eff == WW'(1)) begin
          u_d = '0;
          state_d = ST_B_C;
        end else begin
          u_d = AW'(1);
          state_d = ST_F_RDG;
        end
      end
      ST_F_RDG: begin
        col_ra = base_q + PAW'(u_q);
        state_d = ST_F_G;
      end
      ST_F_G: begin
        g_u_d = col_a_q;
        state_d = ST_F_C1;
      end
      ST_F_C1: begin
        fa_d = fd_res;
        state_d = ST_F_C2;
      end
      ST_F_C2: begin
        if (fa_q > fd_res) begin
          if (q_q == '0) begin
            // The new column hides the whole stack.
            top_s_d = u_q; top_t_d = '0; top_g_d = g_u_q;
            env_we = 1'b1; env_wa = '0; env_wd = {g_u_q, u_q, AW'(0)};
            next_u = 1'b1;
          end else begin
            q_d = q_q - AW'(1);
            env_ra = q_q - AW'(1);
            state_d = ST_F_LD;
          end
        end else begin
          state_d = ST_F_N1;
        end
      end
      ST_F_LD: begin
        {top_g_d, top_s_d, top_t_d} = env_rd_q;
        state_d = ST_F_C1;
      end
      ST_F_N1: begin
        nu_d = fd_res;
        state_d = ST_F_N2;
      end
      ST_F_N2: begin
        if (nu_q < fd_res) begin
          push_en = 1'b1;
          push_start = '0;
        end else begin
          num = nu_q - fd_res;
          rem_d = num;
          den_d = (AW+1)'(u_q - top_s_q) << 1;
          state_d = ST_F_N3;
        end
      end
      ST_F_N3: begin
        if (CMPW'(rem_q) >= CMPW'(lim)) begin
          // The boundary lies beyond the row.
          next_u = 1'b1;
        end else begin
          dv_d = DVW'(den_q) << (AW - 1);
          quot_d = '0;
          cnt_d = CNTW'(AW);
          state_d = ST_F_DIV;
        end
      end
      ST_F_DIV: begin
        dbit = DVW'(rem_q) >= dv_q;
        if (dbit) rem_d = FW'(DVW'(rem_q) - dv_q);
        qn = AW'({quot_q, dbit});
        quot_d = qn;
        dv_d = dv_q >> 1;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          push_en = 1'b1;
          push_start = qn + AW'(1);
        end
      end
      ST_B_C: begin
        dist_we = 1'b1;
        dist_wa = base_q + PAW'(u_q);
        dist_wd = fd_res;
        if (fd_res > max_q) max_d = fd_res;
        if (u_q == '0) begin
          if (row_q + RW'(1) == h_eff) begin
            fetch_cnt_d = '0;
            state_d = ST_OUT;
          end else begin
            base_d = base_q + PAW'(w_eff);
            row_d = row_q + RW'(1);
            state_d = ST_R0;
          end
        end else begin
          u_d = u_q - AW'(1);
          if (u_q == top_t_q && q_q != '0) begin
            q_d = q_q - AW'(1);
            env_ra = q_q - AW'(1);
            state_d = ST_B_LD;
          end
        end
      end
      ST_B_LD: begin
        {top_g_d, top_s_d, top_t_d} = env_rd_q;
        state_d = ST_B_C;
      end
      ST_Q_RD: begin
        res_dist_d = (32'(dist_rd_q) > 32'(DIST_SAT)) ? DIST_SAT : DIST_W'(dist_rd_q);
        if (!any_black_q) begin
          res_dist_d = DIST_SAT;
          res_cost_d = '0;
          res_nb_d = 1'b1;
          state_d = ST_Q_PUT;
        end else begin
          res_nb_d = 1'b0;
          crem_d = m_ext - (FW+2)'(dist_rd_q);
          r_d = '0;
          cnt_d = CNTW'(RATIO_W);
          state_d = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        // One quotient bit of (M - d) * 2^24 / M per cycle.
        dbit = crem_q >= m_ext;
        cr = dbit ? crem_q - m_ext : crem_q;
        crem_d = cr << 1;
        r_d = {r_q[RATIO_W-2:0], dbit};
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          p_d = {r_q[RATIO_W-2:0], dbit};
          cnt_d = CNTW'(POW_STEPS);
          state_d = ST_Q_POW;
        end
      end
      ST_Q_POW: begin
        prod = p_q * r_q;
        p_d = prod[FRAC +: RATIO_W];
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) state_d = ST_Q_CST;
      end
      ST_Q_CST: begin
        sc = (RATIO_W+COST_W)'(COST_SCALE) * (RATIO_W+COST_W)'(p_q);
        res_cost_d = sc[FRAC +: COST_W];
        state_d = ST_Q_PUT;
      end
      ST_Q_PUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_dist_d = res_dist_q;
          out_cost_d = res_cost_q;
          out_nb_d = res_nb_q;
          out_last_d = (fetch_cnt_q + PCW'(1) == total);
          if (fetch_cnt_q + PCW'(1) == total) begin
            fetch_cnt_d = '0;
            load_cnt_d = '0;
            state_d = ST_LOAD;
          end else begin
            fetch_cnt_d = fetch_cnt_q + PCW'(1);
            state_d = ST_OUT;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (push_en) begin
      q_d = q_q + AW'(1);
      env_we = 1'b1;
      env_wa = q_q + AW'(1);
      env_wd = {g_u_q, u_q, push_start};
      top_s_d = u_q; top_t_d = push_start; top_g_d = g_u_q;
      next_u = 1'b1;
    end

    if (next_u) begin
      if (WW'(u_q) + WW'(1) == w_eff) begin
        state_d = ST_B_C;
      end else begin
        u_d = u_q + AW'(1);
        state_d = ST_F_RDG;
      end
    end

    // A register write abandons any image or result stream.
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_IMAGE_WIDTH) img_w_d = cfg_data_i;
      else img_h_d = cfg_data_i;
      load_cnt_d = '0;
      fetch_cnt_d = '0;
      any_black_d = 1'b0;
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      img_w_q <= CFG_RESET_SIZE;
      img_h_q <= CFG_RESET_SIZE;
      load_cnt_q <= '0;
      fetch_cnt_q <= '0;
      any_black_q <= 1'b0;
      out_valid_q <= 1'b0;
      max_q <= '0;
    end else begin
      state_q <= state_d;
      img_w_q <= img_w_d;
      img_h_q <= img_h_d;
      load_cnt_q <= load_cnt_d;
      fetch_cnt_q <= fetch_cnt_d;
      any_black_q <= any_black_d;
      out_valid_q <= out_valid_d;
      max_q <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; base_q <= base_d; row_q <= row_d; u_q <= u_d; q_q <= q_d;
    top_s_q <= top_s_d; top_t_q <= top_t_d; top_g_q <= top_g_d; g_u_q <= g_u_d;
    quot_q <= quot_d; fa_q <= fa_d; nu_q <= nu_d; rem_q <= rem_d;
    den_q <= den_d; dv_q <= dv_d; cnt_q <= cnt_d; crem_q <= crem_d;
    r_q <= r_d; p_q <= p_d;
    res_dist_q <= res_dist_d; res_cost_q <= res_cost_d; res_nb_q <= res_nb_d;
    out_dist_q <= out_dist_d; out_cost_q <= out_cost_d; out_nb_q <= out_nb_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.squared_distance = out_dist_q;
  assign out_o.cost             = out_cost_q;
  assign out_o.no_black         = out_nb_q;
  assign out_o.last             = out_last_q;

  `EDCM_ASSERT(a_load_in_range, clk_i, rst_ni, state_q == ST_LOAD, load_cnt_q < total, "load count past image")
  `EDCM_ASSERT(a_stack_below_u, clk_i, rst_ni, state_q == ST_F_C1 || state_q == ST_F_C2, q_q < u_q, "envelope stack too deep")
  `EDCM_ASSERT(a_scan_after_start, clk_i, rst_ni, state_q == ST_B_C, top_t_q <= u_q, "scan passed envelope start")
  `EDCM_ASSERT_NEXT(a_fetch_reads, clk_i, rst_ni, state_q == ST_OUT && in_beat && in_i.action == ACT_FETCH && !cfg_we_i, state_q == ST_Q_RD, "fetch beat did not read store")

endmodule

>>> test/euclidean_distance_cost_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean distance cost map testbench
// Loads small and extreme-sized grey images with varied black density,
// fetches the distance map and checks every result beat against a
// behavioural distance transform held in a scoreboard class.
// ----------------------------------------------------------------------------
module euclidean_distance_cost_map_tb;
  import edcm_pkg::*;

  localparam int NPIX     = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int COL_FAR  = DEF_MAX_WIDTH + DEF_MAX_HEIGHT;
  localparam int IDLE_MAX = 100000;
  localparam int SETTLE   = 20000;

  typedef struct packed {
    logic [DIST_W-1:0] sq_distance;
    logic [COST_W-1:0] cost;
    logic              no_black;
    logic              last;
  } dist_result_t;

  class distance_map_sb;
    int unsigned  width_reg, height_reg;
    bit           black_px[NPIX];
    int unsigned  col_dist[NPIX];
    int unsigned  sq_dist[NPIX];
    int unsigned  env_site[DEF_MAX_WIDTH];
    int unsigned  env_start[DEF_MAX_WIDTH];
    int unsigned  peak_dist, n_loaded, n_fetched;
    bit           ready_map, seen_black;
    dist_result_t pending[$];
    int           errors;

    function new();
      width_reg  = CFG_RESET_SIZE;
      height_reg = CFG_RESET_SIZE;
    endfunction

    function int unsigned cols();
      return width_reg == 0 ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
    endfunction

    function int unsigned rows();
      return height_reg == 0 ? 1 : (height_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height_reg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      n_loaded   = 0;
      n_fetched  = 0;
      ready_map  = 0;
      seen_black = 0;
    endfunction

    function int unsigned sep_dist(int unsigned x, int unsigned i, int unsigned base);
      int unsigned dx;
      dx = x > i ? x - i : i - x;
      return dx * dx + col_dist[base + i] * col_dist[base + i];
    endfunction

    function void transform();
      int unsigned w, h, base, i, ux, d;
      longint      gu, gi, num;
      longint unsigned den, sep;
      int          q;
      w = cols();
      h = rows();
      peak_dist = 0;
      for (int unsigned x = 0; x < w; x++) begin
        col_dist[x] = black_px[x] ? 0 : COL_FAR;
        for (int unsigned y = 1; y < h; y++) begin
          d = col_dist[x + (y - 1) * w];
          col_dist[x + y * w] = black_px[x + y * w] ? 0 : (d >= COL_FAR ? COL_FAR : d + 1);
        end
        for (int unsigned y = h - 1; y > 0; y--) begin
          d = col_dist[x + y * w];
          if (d < col_dist[x + (y - 1) * w]) col_dist[x + (y - 1) * w] = d + 1;
        end
      end
      for (int unsigned y = 0; y < h; y++) begin
        base = y * w;
        q = 0;
        env_site[0]  = 0;
        env_start[0] = 0;
        for (int unsigned u = 1; u < w; u++) begin
          while (q >= 0 && sep_dist(env_start[q], env_site[q], base) >
                           sep_dist(env_start[q], u, base))
            q--;
          if (q < 0) begin
            q = 0;
            env_site[0]  = u;
            env_start[0] = 0;
          end else begin
            i   = env_site[q];
            gu  = col_dist[base + u];
            gi  = col_dist[base + i];
            num = longint'(u) * u - longint'(i) * i + gu * gu - gi * gi;
            den = 2 * longint'(u - i);
            sep = num < 0 ? 0 : 1 + longint'(num) / den;
            if (sep < w && q + 1 < DEF_MAX_WIDTH) begin
              q++;
              env_site[q]  = u;
              env_start[q] = sep;
            end
          end
        end
        for (int unsigned u = w; u > 0; u--) begin
          ux = u - 1;
          d  = sep_dist(ux, env_site[q], base);
          sq_dist[base + ux] = d;
          if (d > peak_dist) peak_dist = d;
          if (ux == env_start[q] && q > 0) q--;
        end
      end
    endfunction

    function logic [COST_W-1:0] cost_of(int unsigned d);
      longint unsigned m, r, p;
      m = longint'(peak_dist) + 1;
      if (d >= m) return 0;
      r = ((m - d) << FRAC) / m;
      p = r;
      repeat (POW_STEPS) p = (p * r) >> FRAC;
      return COST_W'((COST_SCALE * p) >> FRAC);
    endfunction

    function void note_beat(logic act, logic [GRAY_W-1:0] g);
      int unsigned  total, idx;
      dist_result_t res;
      total = cols() * rows();
      if (act == ACT_LOAD) begin
        if (ready_map) begin
          ready_map = 0;
          n_fetched = 0;
          n_loaded  = 0;
        end
        if (n_loaded == 0) seen_black = 0;
        if (n_loaded < total) begin
          black_px[n_loaded] = (g == 0);
          if (g == 0) seen_black = 1;
          n_loaded++;
        end
        if (n_loaded >= total) begin
          transform();
          ready_map = 1;
          n_fetched = 0;
        end
      end else if (ready_map) begin
        idx = n_fetched < total ? n_fetched : total - 1;
        if (seen_black) begin
          res.sq_distance = sq_dist[idx] > DIST_SAT ? DIST_SAT : DIST_W'(sq_dist[idx]);
          res.cost        = cost_of(sq_dist[idx]);
          res.no_black    = 0;
        end else begin
          res.sq_distance = DIST_SAT;
          res.cost        = 0;
          res.no_black    = 1;
        end
        res.last = (idx + 1 >= total);
        pending = {pending, res};
        if (res.last) begin
          ready_map = 0;
          n_fetched = 0;
          n_loaded  = 0;
        end else begin
          n_fetched = idx + 1;
        end
      end
    endfunction

    function void check_beat(dist_result_t got);
      dist_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat: squared_distance %0d cost %0d",
               got.sq_distance, got.cost);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.sq_distance !== want.sq_distance) begin
        $error("squared_distance: expected %0d, got %0d", want.sq_distance, got.sq_distance);
        errors++;
      end
      if (got.cost !== want.cost) begin
        $error("cost: expected %0d, got %0d", want.cost, got.cost);
        errors++;
      end
      if (got.no_black !== want.no_black) begin
        $error("no_black: expected %0d, got %0d", want.no_black, got.no_black);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  edcm_in_if  in_ch ();
  edcm_out_if out_ch ();

  euclidean_distance_cost_map uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  distance_map_sb sb = new();
  int  n_items;
  int  burst_left;
  int  idle_cycles;
  bit  hold_req;
  logic last_act = ACT_FETCH;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    in_ch.valid  = 0;
    in_ch.action = ACT_LOAD;
    in_ch.gray   = '0;
    out_ch.ready = 0;
  end

  // Receiver: mostly random stalls, with calm stretches and one long hold-off.
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end
      if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ch.ready <= 1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.squared_distance, out_ch.cost, out_ch.no_black, out_ch.last});
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(logic act, logic [GRAY_W-1:0] g);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid  <= 1;
    in_ch.action <= act;
    in_ch.gray   <= g;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_beat(act, g);
    last_act = act;
    n_items++;
  endtask

  // Drain every result; after a load the block may still be transforming.
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    if (last_act == ACT_LOAD) repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, val);
    last_act = ACT_FETCH;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    end else begin
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
      write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    end
  endtask

  task automatic load_pixels(int unsigned n, int black_pct);
    repeat (n)
      send_beat(ACT_LOAD, ($urandom_range(0, 99) < black_pct) ? 8'd0 :
                          GRAY_W'($urandom_range(1, 255)));
  endtask

  initial begin
    int unsigned w, h, total, n_fetch;
    int          pct, pick;
    bit          held;
    n_items = 0;
    burst_left = 0;
    idle_cycles = 0;
    hold_req = 0;
    held = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // Directed: one pixel images with an idle fetch, then two by two images with a reload over pending results.
    set_size(0, 0);
    send_beat(ACT_LOAD, 8'd0);
    send_beat(ACT_FETCH, 8'hFF);
    send_beat(ACT_LOAD, 8'hFF);
    send_beat(ACT_FETCH, 8'd0);
    send_beat(ACT_FETCH, 8'd0);
    send_beat(ACT_LOAD, 8'd1);
    send_beat(ACT_LOAD, 8'd0);
    send_beat(ACT_FETCH, 8'd0);
    set_size(2, 2);
    send_beat(ACT_LOAD, 8'd0);
    send_beat(ACT_LOAD, 8'd128);
    send_beat(ACT_LOAD, 8'd255);
    send_beat(ACT_LOAD, 8'd7);
    repeat (4) send_beat(ACT_FETCH, 8'd0);
    load_pixels(4, 0);
    repeat (2) send_beat(ACT_FETCH, 8'd0);
    load_pixels(2, 50);
    set_size(3, 1);

    while (n_items < 1950) begin
      // Near the end only small images are used, so the run stays near its size.
      pick = $urandom_range((n_items > 1400) ? 4 : 0, 11);
      case (pick)
        0: begin w = 256; h = 1; end
        1: begin w = 511; h = 1; end
        2: begin w = 1; h = 511; end
        3: begin w = 1; h = 256; end
        4: begin w = 0; h = $urandom_range(1, 12); end
        default: begin w = $urandom_range(1, 10); h = $urandom_range(1, 10); end
      endcase
      set_size(w, h);
      total = sb.cols() * sb.rows();
      repeat (pick < 4 ? 1 : $urandom_range(1, 3)) begin
        case ($urandom_range(0, 4))
          0: pct = 0;
          1: pct = 3;
          2: pct = 100;
          default: pct = $urandom_range(5, 40);
        endcase
        if ($urandom_range(0, 19) == 0) send_beat(ACT_FETCH, GRAY_W'($urandom));
        load_pixels(total, pct);
        n_fetch = ($urandom_range(0, 19) == 0) ? $urandom_range(0, total) : total;
        if (!held && total > 20) begin
          hold_req = 1;
          held = 1;
        end
        repeat (n_fetch) send_beat(ACT_FETCH, GRAY_W'($urandom));
        if ($urandom_range(0, 9) == 0) drain();
      end
      if ($urandom_range(0, 9) == 0) load_pixels($urandom_range(1, total), 30);
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
